// ----- rtl/bltcm_pkg.sv -----
// Package for the byte-lane TCM sub-word access core.
// Holds access size codes, address split constants, the strobe bundle and
// helpers for store byte masks and load alignment. No dependencies.
package bltcm_pkg;

  // Default memory depth in 32-bit words
  localparam int unsigned DepthWordsDef = 16384;

  // Byte address split: two offset bits, the rest word index
  localparam int unsigned AddrW    = 16;
  localparam int unsigned WordIdxW = AddrW - 2;

  // Constant-divisor reduction of the word index: q = (x * M) >> RecipShift
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW     = 29;

  // Access size codes
  localparam logic [4:0] SizeByte      = 5'h01;
  localparam logic [4:0] SizeHalf      = 5'h03;
  localparam logic [4:0] SizeByteSExt  = 5'h11;
  localparam logic [4:0] SizeHalfSExt  = 5'h13;

  // Side-band strobes carried alongside each beat
  typedef struct packed {
    logic rd;
    logic wr;
    logic first_rd;
    logic take_rd;
  } flags_t;

  // Lanes a store touches for a given size and byte offset; bytes past
  // lane 3 are dropped
  function automatic logic [3:0] store_lane_mask(input logic [4:0] size,
                                                 input logic [1:0] off);
    logic [3:0] base;
    begin
      if (size == SizeByte) begin
        base = 4'b0001;
      end else if (size == SizeHalf) begin
        base = 4'b0011;
      end else begin
        base = 4'b1111;
      end
      store_lane_mask = base << off;
    end
  endfunction

  // Align the read word to the byte offset, then mask or sign-extend
  function automatic logic [31:0] format_load(input logic [31:0] word,
                                              input logic [1:0]  off,
                                              input logic [4:0]  size);
    logic [31:0] data;
    begin
      data = word >> {off, 3'b000};
      unique case (size)
        SizeByte:     format_load = {24'h000000, data[7:0]};
        SizeHalf:     format_load = {16'h0000, data[15:0]};
        SizeByteSExt: format_load = {{24{data[7]}}, data[7:0]};
        SizeHalfSExt: format_load = {{16{data[15]}}, data[15:0]};
        default:      format_load = data;
      endcase
    end
  endfunction

endpackage

// ----- rtl/bltcm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address write). No dependencies.
module bltcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/byte_lane_tcm_subword_access_core.sv -----
// Byte-lane TCM with sub-word loads and stores.
// Pipeline steps: index reduction, lane RAM access, alignment into the
// output register. Throughput: one beat per cycle sustained while out_stall_i
// is low; the lane RAM read port sets it.
// Reset clears the pipeline valids and the held address and size to zero;
// lane RAM contents are undefined until written and need no clearing pass.
module byte_lane_tcm_subword_access_core
  import bltcm_pkg::*;
#(
  parameter int unsigned DEPTH_WORDS = DepthWordsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             chip_select_i,
  input  logic             func_i,
  input  logic [AddrW-1:0] byte_address_i,
  input  logic [31:0]      store_data_i,
  input  logic [4:0]       access_size_i,
  input  logic             read_flag_i,
  input  logic             write_flag_i,
  input  logic             first_read_flag_i,
  input  logic             take_read_flag_i,
  // Output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      load_data_o,
  output logic             read_flag_q_o,
  output logic             write_flag_q_o,
  output logic             first_read_flag_q_o,
  output logic             take_read_flag_q_o
);

  localparam int unsigned IdxW = $clog2(DEPTH_WORDS);
  localparam int unsigned DepW = $clog2(DEPTH_WORDS + 1);
  localparam int unsigned RemW = WordIdxW + DepW;
  localparam logic [RecipW-1:0] RecipM =
      RecipW'((64'd1 << RecipShift) / DEPTH_WORDS);
  localparam logic [RemW-1:0] DepthRem = RemW'(DEPTH_WORDS);

  // Handshake / pipeline control
  logic in_acc;
  logic a_valid_q, a_free, a_adv;
  logic b_valid_q, b_free, b_adv;
  logic out_valid_q, out_free;

  // Stage A: registered beat plus index quotient
  logic                  a_cs_q, a_func_q;
  logic [AddrW-1:0]      a_addr_q;
  logic [31:0]           a_wdata_q;
  logic [4:0]            a_size_q;
  flags_t                a_flags_q;
  logic [WordIdxW-1:0]   a_quot_q;

  // Held load address and size
  logic [IdxW-1:0]       held_idx_q;
  logic [1:0]            held_off_q;
  logic [4:0]            held_size_q;

  // Stage B: RAM read in flight, plus same-entry forwarding
  logic [1:0]            b_off_q;
  logic [4:0]            b_size_q;
  flags_t                b_flags_q;
  logic [3:0]            b_fwd_q;
  logic [3:0][7:0]       b_fbyte_q;

  // Output register
  logic [31:0]           load_data_q;
  flags_t                out_flags_q;

  // Datapath nets
  logic [WordIdxW+RecipW-1:0] quot_prod;
  logic [RemW-1:0]       rem_raw, rem_fix;
  logic [IdxW-1:0]       wr_idx, rd_idx;
  logic [1:0]            rd_off;
  logic [4:0]            rd_size;
  logic [3:0]            lane_mask, lane_we;
  logic [3:0][7:0]       lane_wdata, lane_rdata, word_merged;
  logic                  rd_en;
  flags_t                in_flags;

  // Flow control: each stage moves when the one after it has room
  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_adv      = b_valid_q && out_free;
  assign b_free     = !b_valid_q || out_free;
  assign a_adv      = a_valid_q && b_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_stall_o = !a_free;
  assign in_acc     = in_valid_i && a_free;

  assign in_flags = '{rd: read_flag_i, wr: write_flag_i,
                      first_rd: first_read_flag_i, take_rd: take_read_flag_i};

  // Quotient of the word index by the depth (may be one short)
  assign quot_prod = byte_address_i[AddrW-1:2] * RecipM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cs_q    <= chip_select_i;
      a_func_q  <= func_i;
      a_addr_q  <= byte_address_i;
      a_wdata_q <= store_data_i;
      a_size_q  <= access_size_i;
      a_flags_q <= in_flags;
      a_quot_q  <= quot_prod[RecipShift +: WordIdxW];
    end
  end

  // Remainder with one correction step gives the wrapped word index
  assign rem_raw = RemW'(a_addr_q[AddrW-1:2]) - RemW'(a_quot_q) * DepthRem;
  assign rem_fix = (rem_raw >= DepthRem) ? (rem_raw - DepthRem) : rem_raw;
  assign wr_idx  = IdxW'(rem_fix);

  // Store lanes: data shifted up to the offset, tail past lane 3 dropped
  assign lane_mask  = store_lane_mask(a_size_q, a_addr_q[1:0]);
  assign lane_we    = (a_adv && a_cs_q && a_func_q) ? lane_mask : 4'b0000;
  assign lane_wdata = a_wdata_q << {a_addr_q[1:0], 3'b000};

  // Load at the new address when selected, else at the held one
  assign rd_en   = a_adv;
  assign rd_idx  = a_cs_q ? wr_idx         : held_idx_q;
  assign rd_off  = a_cs_q ? a_addr_q[1:0]  : held_off_q;
  assign rd_size = a_cs_q ? a_size_q       : held_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_idx_q  <= '0;
      held_off_q  <= '0;
      held_size_q <= '0;
    end else if (a_adv && a_cs_q) begin
      held_idx_q  <= wr_idx;
      held_off_q  <= a_addr_q[1:0];
      held_size_q <= a_size_q;
    end
  end

  // Lane RAMs
  for (genvar l = 0; l < 4; l++) begin : g_lane
    bltcm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH_WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[l]),
      .waddr_i (wr_idx),
      .wdata_i (lane_wdata[l]),
      .re_i    (rd_en),
      .raddr_i (rd_idx),
      .rdata_o (lane_rdata[l])
    );
  end

  // Stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  // A write always targets the entry read in the same cycle: forward it
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_off_q   <= rd_off;
      b_size_q  <= rd_size;
      b_flags_q <= a_flags_q;
      b_fwd_q   <= lane_we;
      b_fbyte_q <= lane_wdata;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_merge
    assign word_merged[l] = b_fwd_q[l] ? b_fbyte_q[l] : lane_rdata[l];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      load_data_q <= format_load(word_merged, b_off_q, b_size_q);
      out_flags_q <= b_flags_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign load_data_o         = load_data_q;
  assign read_flag_q_o       = out_flags_q.rd;
  assign write_flag_q_o      = out_flags_q.wr;
  assign first_read_flag_q_o = out_flags_q.first_rd;
  assign take_read_flag_q_o  = out_flags_q.take_rd;

`ifndef SYNTHESIS
  // Reduced index stays inside the memory
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |-> (rem_fix < DepthRem))
    else $error("word index reduction out of range");

  // Held index never points past the memory
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    RemW'(held_idx_q) < DepthRem)
    else $error("held index out of range");

  // Any lane write comes with a read of the same entry (forwarding relies on it)
  a_wr_with_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_we != 4'b0000) |-> (rd_en && rd_idx == wr_idx))
    else $error("lane write without matching read");

  // RAM read data is not overwritten while stage B is held
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !out_free) |-> !rd_en)
    else $error("RAM read while stage B stalled");

  // A result beat follows a stage B beat moving on
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> out_valid_q)
    else $error("stage B beat lost");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for byte_lane_tcm_subword_access_core: directed table then random
// accesses, checked beat by beat against an in-bench model. Depends on bltcm_pkg.
module tb_top
  import bltcm_pkg::*;
();

  // Codes outside byte/half that move a full word
  localparam logic [4:0] SizeWord    = 5'h00;
  localparam logic [4:0] SizeWordAlt = 5'h1f;
  localparam int         PoolSize    = 24;
  localparam int         NumDirected = 22;
  localparam int         NumRandom   = 550;

  typedef struct packed {
    logic        cs;
    logic        fn;
    logic [15:0] addr;
    logic [31:0] wdat;
    logic [4:0]  size;
    flags_t      fl;
  } access_t;

  typedef struct packed {
    logic [31:0] data;
    flags_t      fl;
  } load_beat_t;

  typedef struct packed {
    logic        cs;
    logic        fn;
    logic [15:0] addr;
    logic [31:0] wdat;
    logic [4:0]  size;
    flags_t      fl;
    logic        has_exp;
    logic [31:0] exp_data;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_FREE, RX_LIGHT, RX_PATTERN, RX_HEAVY
  } rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        chip_select = 1'b0;
  logic        func = 1'b0;
  logic [15:0] byte_address = 16'h0000;
  logic [31:0] store_data = 32'h0;
  logic [4:0]  access_size = 5'h00;
  logic        read_flag = 1'b0;
  logic        write_flag = 1'b0;
  logic        first_read_flag = 1'b0;
  logic        take_read_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] load_data;
  logic        read_flag_q;
  logic        write_flag_q;
  logic        first_read_flag_q;
  logic        take_read_flag_q;

  // Model state: lanes, which lanes hold data, held address and size
  logic [7:0]  lane_mem [4][DepthWordsDef];
  bit   [3:0]  lane_written [DepthWordsDef];
  logic [15:0] held_addr = 16'h0000;
  logic [4:0]  held_size = 5'h00;
  logic [13:0] word_pool [PoolSize];

  load_beat_t  load_q [$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          no_gap_left = 0;
  logic        hold_req = 1'b0;

  // Directed accesses; typed expectations where they read off directly
  dir_row_t dir_rows [NumDirected] = '{
    '{1'b1, 1'b1, 16'h0000, 32'h8081_7f80, SizeWord,     4'b1010, 1'b1, 32'h8081_7f80},
    '{1'b1, 1'b1, 16'hfffc, 32'hffff_ffff, SizeWordAlt,  4'b0101, 1'b1, 32'hffff_ffff},
    '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, SizeByte,     4'b0000, 1'b1, 32'h0000_0080},
    '{1'b1, 1'b0, 16'h0000, 32'hffff_ffff, SizeByteSExt, 4'b1111, 1'b1, 32'hffff_ff80},
    '{1'b1, 1'b0, 16'h0001, 32'h0000_0000, SizeByteSExt, 4'b0001, 1'b1, 32'h0000_007f},
    '{1'b1, 1'b0, 16'h0002, 32'h0000_0000, SizeHalf,     4'b0010, 1'b1, 32'h0000_8081},
    '{1'b1, 1'b0, 16'h0002, 32'h0000_0000, SizeHalfSExt, 4'b0100, 1'b1, 32'hffff_8081},
    '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, SizeHalfSExt, 4'b1000, 1'b1, 32'h0000_7f80},
    '{1'b1, 1'b0, 16'h0003, 32'h0000_0000, SizeWord,     4'b0000, 1'b1, 32'h0000_0080},
    '{1'b0, 1'b0, 16'hffff, 32'hffff_ffff, SizeHalf,     4'b1111, 1'b1, 32'h0000_0080},
    '{1'b1, 1'b1, 16'h0001, 32'haaaa_aa55, SizeByte,     4'b0000, 1'b1, 32'h0000_0055},
    '{1'b1, 1'b1, 16'h0003, 32'h0000_1234, SizeHalf,     4'b0000, 1'b1, 32'h0000_0034},
    '{1'b1, 1'b1, 16'h0002, 32'hdead_beef, SizeByteSExt, 4'b0000, 1'b0, 32'h0},
    '{1'b1, 1'b0, 16'h0000, 32'h0000_0000, SizeWord,     4'b0000, 1'b0, 32'h0},
    '{1'b0, 1'b1, 16'h0000, 32'h0000_0000, SizeWord,     4'b1010, 1'b0, 32'h0},
    '{1'b1, 1'b1, 16'hffff, 32'h0000_0000, SizeByte,     4'b0000, 1'b1, 32'h0000_0000},
    '{1'b1, 1'b0, 16'hfffc, 32'h0000_0000, SizeWord,     4'b1111, 1'b1, 32'h00ff_ffff},
    '{1'b1, 1'b1, 16'h5554, 32'h0000_0000, SizeWord,     4'b0000, 1'b1, 32'h0000_0000},
    '{1'b1, 1'b1, 16'haaa8, 32'h5555_5555, SizeWord,     4'b0000, 1'b1, 32'h5555_5555},
    '{1'b1, 1'b0, 16'h5557, 32'h0000_0000, SizeHalfSExt, 4'b0000, 1'b1, 32'h0000_0000},
    '{1'b1, 1'b0, 16'haaaa, 32'h0000_0000, SizeHalfSExt, 4'b0000, 1'b1, 32'h0000_5555},
    '{1'b1, 1'b1, 16'hfffd, 32'h1234_5678, SizeHalfSExt, 4'b0000, 1'b0, 32'h0}
  };

  byte_lane_tcm_subword_access_core u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .chip_select_i       (chip_select),
    .func_i              (func),
    .byte_address_i      (byte_address),
    .store_data_i        (store_data),
    .access_size_i       (access_size),
    .read_flag_i         (read_flag),
    .write_flag_i        (write_flag),
    .first_read_flag_i   (first_read_flag),
    .take_read_flag_i    (take_read_flag),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .load_data_o         (load_data),
    .read_flag_q_o       (read_flag_q),
    .write_flag_q_o      (write_flag_q),
    .first_read_flag_q_o (first_read_flag_q),
    .take_read_flag_q_o  (take_read_flag_q)
  );

  always #1 clk = ~clk;

  // Bytes a store moves: only the byte and half codes are short
  function automatic int store_bytes(input logic [4:0] size);
    if (size == SizeByte) begin
      return 1;
    end else if (size == SizeHalf) begin
      return 2;
    end
    return 4;
  endfunction

  // One accepted beat through the memory model: store, latch, load
  task automatic tcm_access(input access_t a, output load_beat_t r);
    logic [13:0] widx;
    logic [1:0]  ln;
    int          nb;
    logic [31:0] word;
    logic [31:0] data;
    if (a.cs && a.fn) begin
      widx = 14'((a.addr >> 2) % DepthWordsDef);
      nb   = store_bytes(a.size);
      // bytes past lane 3 fall off the word
      for (int k = 0; k < nb; k++) begin
        if (int'(a.addr[1:0]) + k < 4) begin
          ln = 2'(int'(a.addr[1:0]) + k);
          lane_mem[ln][widx]     = a.wdat[8*k +: 8];
          lane_written[widx][ln] = 1'b1;
        end
      end
    end
    if (a.cs) begin
      held_addr = a.addr;
      held_size = a.size;
    end
    widx = 14'((held_addr >> 2) % DepthWordsDef);
    word = {lane_mem[3][widx], lane_mem[2][widx], lane_mem[1][widx], lane_mem[0][widx]};
    data = word >> (8 * held_addr[1:0]);
    case (held_size)
      SizeByte:     data = data & 32'h0000_00ff;
      SizeHalf:     data = data & 32'h0000_ffff;
      SizeByteSExt: data = {{24{data[7]}}, data[7:0]};
      SizeHalfSExt: data = {{16{data[15]}}, data[15:0]};
      default:      data = data;
    endcase
    r.data = data;
    r.fl   = a.fl;
  endtask

  // Random access over the word pool; never lets a half-written word be read
  function automatic access_t rand_access();
    access_t     a;
    int          r;
    logic [13:0] widx;
    logic [1:0]  off;
    logic [3:0]  touched;
    a.cs = ($urandom_range(0, 4) != 0);
    a.fn = 1'($urandom_range(0, 1));
    widx = word_pool[$urandom_range(0, PoolSize - 1)];
    off  = 2'($urandom_range(0, 3));
    a.addr = {widx, off};
    r = $urandom_range(0, 9);
    case (r)
      0, 1:    a.size = SizeByte;
      2:       a.size = SizeHalf;
      3, 4:    a.size = SizeByteSExt;
      5:       a.size = SizeHalfSExt;
      6:       a.size = SizeWord;
      7:       a.size = SizeWordAlt;
      default: a.size = 5'($urandom_range(0, 31));
    endcase
    r = $urandom_range(0, 7);
    a.wdat = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
    a.fl   = 4'($urandom_range(0, 15));
    touched = 4'h0;
    if (a.cs && a.fn) begin
      touched = 4'(((1 << store_bytes(a.size)) - 1) << off);
    end
    // word not yet whole: turn the beat into an aligned full-word store
    if (a.cs && ((lane_written[widx] | touched) != 4'hf)) begin
      a.fn   = 1'b1;
      a.addr = {widx, 2'b00};
      a.size = 5'($urandom_range(0, 31));
      if (a.size == SizeByte || a.size == SizeHalf) begin
        a.size = SizeWord;
      end
    end
    return a;
  endfunction

  // Offer one beat in bursts with random gaps; predict once it is taken
  task automatic offer(input access_t a);
    load_beat_t want;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
    in_valid        <= 1'b1;
    chip_select     <= a.cs;
    func            <= a.fn;
    byte_address    <= a.addr;
    store_data      <= a.wdat;
    access_size     <= a.size;
    read_flag       <= a.fl.rd;
    write_flag      <= a.fl.wr;
    first_read_flag <= a.fl.first_rd;
    take_read_flag  <= a.fl.take_rd;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    tcm_access(a, want);
    load_q.push_back(want);
  endtask

  // Hold the input low until every expected beat is back
  task automatic drain();
    in_valid <= 1'b0;
    wait (load_q.size() == 0);
    @(posedge clk);
  endtask

  // Stimulus: reset, directed table, random accesses, end of run
  initial begin : stimulus
    access_t    a;
    load_beat_t want;
    for (int i = 0; i < PoolSize; i++) begin
      word_pool[i] = 14'($urandom);
    end
    word_pool[0] = 14'h0000;
    word_pool[1] = 14'h3fff;
    word_pool[2] = 14'h1555;
    word_pool[3] = 14'h2aaa;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      a = '{dir_rows[i].cs, dir_rows[i].fn, dir_rows[i].addr, dir_rows[i].wdat,
            dir_rows[i].size, dir_rows[i].fl};
      offer(a);
      if (dir_rows[i].has_exp) begin
        // typed value replaces the model's guess for this beat
        want = load_q.pop_back();
        want.data = dir_rows[i].exp_data;
        load_q.push_back(want);
      end
    end
    drain();

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 150) begin
        // long receiver hold-off while beats keep coming back to back
        hold_req    = 1'b1;
        no_gap_left = 80;
      end
      if (i == 350) begin
        drain();
      end
      offer(rand_access());
    end
    drain();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    rx_mode_e mode;
    int       left;
    bit       held;
    mode = RX_FREE;
    left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (90) @(posedge clk);
      end
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(8, 64);
      end
      left--;
      case (mode)
        RX_FREE:    out_stall <= 1'b0;
        RX_LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
        RX_PATTERN: out_stall <= (left % 3 == 0);
        default:    out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result beats sampled mid-cycle, compared with the oldest expectation
  always @(negedge clk) begin : check_results
    load_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (load_q.size() == 0) begin
        $display("%0t: load_data expected none got %h", $time, load_data);
        mismatches++;
      end else begin
        want = load_q.pop_front();
        compare_field("load_data", want.data, load_data);
        compare_field("read_flag_q", 32'(want.fl.rd), 32'(read_flag_q));
        compare_field("write_flag_q", 32'(want.fl.wr), 32'(write_flag_q));
        compare_field("first_read_flag_q", 32'(want.fl.first_rd),
                      32'(first_read_flag_q));
        compare_field("take_read_flag_q", 32'(want.fl.take_rd),
                      32'(take_read_flag_q));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
